// File: rtl/ppmt_pkg.sv
// Shared constants, codes and widths for the optical PPM transceiver.
// No dependencies; imported by optical_ppm_transceiver and its testbench.
package ppmt_pkg;

    localparam int PAYLOAD_BYTES = 64;
    localparam int STORE_DEPTH   = 2 * PAYLOAD_BYTES;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int POS_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 8;
    localparam int PHASE_W  = 5;
    localparam int ECOUNT_W = 4;
    localparam int PAIR_W   = 2;
    localparam int SYM_W    = 2;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [PHASE_W-1:0] FRAME_TICKS = 5'd24;
    localparam logic [PHASE_W-1:0] PH_SYNC_RISE = 5'd0;
    localparam logic [PHASE_W-1:0] PH_HI0_OFF   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_HI0_ON    = 5'd5;
    localparam logic [PHASE_W-1:0] PH_HI1_OFF   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_HI1_ON    = 5'd9;
    localparam logic [PHASE_W-1:0] PH_SYNC_FALL = 5'd12;
    localparam logic [PHASE_W-1:0] PH_LO0_ON    = 5'd15;
    localparam logic [PHASE_W-1:0] PH_LO0_OFF   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_LO1_ON    = 5'd19;
    localparam logic [PHASE_W-1:0] PH_LO1_OFF   = 5'd21;
    localparam logic [PHASE_W-1:0] PH_LOAD      = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ALIGN     = 5'd1;

    localparam logic [ECOUNT_W-1:0] EDGE_LIMIT   = 4'd10;
    localparam logic [ECOUNT_W-1:0] DECODE_EDGES = 4'd6;
    localparam logic [ECOUNT_W-1:0] SYNC_EDGES   = 4'd2;
    localparam logic [ECOUNT_W-1:0] MIN_DATA_EDGES = 4'd3;

    localparam logic [CFG_W-1:0] SYNC_RISE_RESET    = 8'd22;
    localparam logic [CFG_W-1:0] LOCK_TIMEOUT_RESET = 8'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_RISE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TIMEOUT = 1'd1;

    localparam logic [1:0] BUF_NONE   = 2'd0;
    localparam logic [1:0] BUF_FIRST  = 2'd1;
    localparam logic [1:0] BUF_SECOND = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_EDGE  = 2'd1,
        OP_BYTE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

endpackage

// File: rtl/optical_ppm_transceiver.sv
// Optical 4-PPM transceiver: transmit frame sequencer, edge-timing receiver, payload buffers.
// Depends on ppmt_pkg and ppmt_ram.
//
// Every input item (tick, light edge, payload byte or clear) yields exactly one result item,
// in the cycle after acceptance, and a new item is taken every cycle while the result register
// is empty or being drained. Payload bytes live in a two-buffer RAM of 2*PAYLOAD_BYTES entries;
// the tick that enters frame phase 3 reads the next byte, and its registered output supplies
// the bit pair for the following ticks. Configuration writes are taken at any time and
// should be made while no item is in flight.
module optical_ppm_transceiver
    import ppmt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [0] level, [8:1] data_byte, rest zero
    input  logic [1:0]           i_s_axis_tuser,  // [1:0] opcode
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [0] led_on, [2:1] symbol, [3] locked
    output logic                 o_m_axis_tuser,  // [0] symbol_valid
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]    r_sync_rise;
    logic [CFG_W-1:0]    r_lock_timeout;

    logic [TIME_W-1:0]   r_time,       n_time;
    logic [PHASE_W-1:0]  r_phase,      n_phase;
    logic                r_led,        n_led;
    logic                r_rx_sync,    n_rx_sync;
    logic                r_rx_locked,  n_rx_locked;
    logic [ECOUNT_W-1:0] r_ecount,     n_ecount;
    logic [TIME_W-1:0]   r_kept [3];
    logic [TIME_W-1:0]   n_kept [3];
    logic [FILL_W-1:0]   r_len  [2];
    logic [FILL_W-1:0]   n_len  [2];
    logic [POS_W-1:0]    r_pos  [2];
    logic [POS_W-1:0]    n_pos  [2];
    logic [PAIR_W-1:0]   r_pair [2];
    logic [PAIR_W-1:0]   n_pair [2];
    logic [1:0]          r_active,     n_active;
    logic [1:0]          r_next,       n_next;
    logic                r_fill_buf,   n_fill_buf;
    logic [FILL_W-1:0]   r_fill_idx,   n_fill_idx;
    logic                r_sending,    n_sending;
    logic [PAIR_W-1:0]   r_sel,        n_sel;

    logic                r_out_valid,  n_out_valid;
    logic                r_out_led;
    logic                r_out_svalid, n_out_svalid;
    logic [SYM_W-1:0]    r_out_sym,    n_out_sym;
    logic                r_out_locked;

    logic                w_accept;
    t_opcode             w_op;
    logic                w_level;
    logic [BYTE_W-1:0]   w_data;
    logic                w_last;

    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic                w_ram_re;
    logic [ADDR_W-1:0]   w_ram_raddr;
    logic [BYTE_W-1:0]   w_ram_rdata;
    logic [2:0]          w_bit_idx;
    logic                w_bit_high;
    logic                w_bit_low;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op     = t_opcode'(i_s_axis_tuser);
    assign w_level  = i_s_axis_tdata[0];
    assign w_data   = i_s_axis_tdata[BYTE_W:1];
    assign w_last   = i_s_axis_tlast;

    assign w_bit_idx  = 3'd7 - {r_sel, 1'b0};
    assign w_bit_high = w_ram_rdata[w_bit_idx];
    assign w_bit_low  = w_ram_rdata[w_bit_idx - 3'd1];

    ppmt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_data),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        logic [PHASE_W-1:0]  ph_inc;
        logic                b;
        logic [FILL_W-1:0]   pos_inc;
        logic [ECOUNT_W-1:0] ec;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   half;
        logic signed [8:0]   diff;
        logic signed [8:0]   dhalf;
        logic [TIME_W-1:0]   late;
        logic                fb;
        logic [FILL_W-1:0]   fi;

        n_time      = r_time;
        n_phase     = r_phase;
        n_led       = r_led;
        n_rx_sync   = r_rx_sync;
        n_rx_locked = r_rx_locked;
        n_ecount    = r_ecount;
        n_kept      = r_kept;
        n_len       = r_len;
        n_pos       = r_pos;
        n_pair      = r_pair;
        n_active    = r_active;
        n_next      = r_next;
        n_fill_buf  = r_fill_buf;
        n_fill_idx  = r_fill_idx;
        n_sending   = r_sending;
        n_sel       = r_sel;
        n_out_svalid = 1'b0;
        n_out_sym   = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = '0;

        ph_inc  = r_phase + 5'd1;
        b       = 1'b0;
        pos_inc = '0;
        ec      = r_ecount;
        now     = r_time;
        half    = r_kept[1];
        diff    = $signed({1'b0, now}) - $signed({1'b0, half});
        dhalf   = (diff + $signed({8'd0, diff[8]})) >>> 1;
        late    = TIME_W'(dhalf) + half;
        fb      = r_fill_buf;
        fi      = r_fill_idx;

        if (w_accept) begin
            case (w_op)
                OP_TICK: begin
                    n_time = r_time + 8'd1;
                    case (r_phase)
                        PH_SYNC_RISE: n_led = 1'b1;
                        PH_HI0_OFF: if (r_sending && !w_bit_high) n_led = 1'b0;
                        PH_HI0_ON:  if (r_sending && !w_bit_high) n_led = 1'b1;
                        PH_HI1_OFF: if (r_sending && w_bit_high)  n_led = 1'b0;
                        PH_HI1_ON:  if (r_sending && w_bit_high)  n_led = 1'b1;
                        PH_SYNC_FALL: n_led = 1'b0;
                        PH_LO0_ON:  if (r_sending && !w_bit_low) n_led = 1'b1;
                        PH_LO0_OFF: if (r_sending && !w_bit_low) n_led = 1'b0;
                        PH_LO1_ON:  if (r_sending && w_bit_low)  n_led = 1'b1;
                        PH_LO1_OFF: if (r_sending && w_bit_low)  n_led = 1'b0;
                        default: ;
                    endcase
                    n_phase = (ph_inc >= FRAME_TICKS) ? '0 : ph_inc;
                    if (n_phase == PH_LOAD) begin
                        if (r_next != r_active) begin
                            n_active = r_next;
                        end else if (r_sending && r_active != BUF_NONE) begin
                            b = r_active[1];
                            n_pair[b] = r_pair[b] + 2'd1;
                            if (n_pair[b] == '0) begin
                                pos_inc = FILL_W'(r_pos[b]) + 1'b1;
                                n_pos[b] = (pos_inc >= r_len[b]) ? '0 : POS_W'(pos_inc);
                            end
                        end
                        n_sending = n_active != BUF_NONE;
                        if (n_sending) begin
                            b = n_active[1];
                            n_sel = n_pair[b];
                            w_ram_re = 1'b1;
                            w_ram_raddr = b ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(n_pos[b])
                                            : ADDR_W'(n_pos[b]);
                        end
                    end
                end
                OP_EDGE: begin
                    if (r_rx_sync || r_rx_locked) begin
                        if (r_ecount < EDGE_LIMIT) begin
                            if (r_ecount == 4'd0) n_kept[0] = now;
                            else if (r_ecount == 4'd2) n_kept[1] = now;
                            else if (r_ecount == 4'd3) n_kept[2] = now;
                            ec = r_ecount + 4'd1;
                        end
                        n_ecount = ec;
                        if (w_level && now > r_sync_rise) begin
                            if (ec == SYNC_EDGES) begin
                                n_time = 8'd1;
                                n_ecount = '0;
                                n_phase = PH_ALIGN;
                                n_led = 1'b1;
                                n_rx_sync = 1'b0;
                                n_rx_locked = 1'b1;
                            end else if (ec > MIN_DATA_EDGES) begin
                                n_time = 8'd1;
                                n_ecount = '0;
                                n_led = 1'b1;
                                if (ec == DECODE_EDGES) begin
                                    n_out_svalid = 1'b1;
                                    n_out_sym = {r_kept[0] >= (half >> 1), r_kept[2] >= late};
                                    n_phase = PH_ALIGN;
                                    n_rx_sync = 1'b0;
                                    n_rx_locked = 1'b1;
                                end else begin
                                    n_rx_locked = 1'b0;
                                end
                            end
                        end else if (now > r_lock_timeout) begin
                            if (w_level) begin
                                n_rx_locked = 1'b0;
                                n_time = 8'd1;
                                n_ecount = '0;
                                n_led = 1'b1;
                                n_rx_sync = 1'b1;
                            end else begin
                                n_rx_locked = 1'b0;
                                n_rx_sync = 1'b0;
                            end
                        end
                    end else if (w_level) begin
                        n_time = 8'd1;
                        n_ecount = '0;
                        n_led = 1'b1;
                        n_rx_sync = 1'b1;
                    end
                end
                OP_BYTE: begin
                    if (r_fill_idx == '0) begin
                        fb = (r_next == BUF_FIRST);
                    end
                    n_fill_buf = fb;
                    if (r_fill_idx < FILL_W'(PAYLOAD_BYTES)) begin
                        w_ram_we = 1'b1;
                        w_ram_waddr = fb ? ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(r_fill_idx)
                                         : ADDR_W'(r_fill_idx);
                        fi = r_fill_idx + 1'b1;
                    end
                    n_fill_idx = fi;
                    if (w_last) begin
                        n_len[fb]  = fi;
                        n_pos[fb]  = '0;
                        n_pair[fb] = '0;
                        n_next     = fb ? BUF_SECOND : BUF_FIRST;
                        n_fill_idx = '0;
                    end
                end
                OP_CLEAR: n_next = BUF_NONE;
                default: ;
            endcase
        end

        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_rise    <= SYNC_RISE_RESET;
            r_lock_timeout <= LOCK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_RISE:    r_sync_rise    <= i_cfg_data;
                CFG_LOCK_TIMEOUT: r_lock_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_phase     <= '0;
            r_led       <= 1'b0;
            r_rx_sync   <= 1'b0;
            r_rx_locked <= 1'b0;
            r_ecount    <= '0;
            r_active    <= BUF_NONE;
            r_next      <= BUF_NONE;
            r_fill_buf  <= 1'b0;
            r_fill_idx  <= '0;
            r_sending   <= 1'b0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_time      <= n_time;
            r_phase     <= n_phase;
            r_led       <= n_led;
            r_rx_sync   <= n_rx_sync;
            r_rx_locked <= n_rx_locked;
            r_ecount    <= n_ecount;
            r_active    <= n_active;
            r_next      <= n_next;
            r_fill_buf  <= n_fill_buf;
            r_fill_idx  <= n_fill_idx;
            r_sending   <= n_sending;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept <= n_kept;
        r_len  <= n_len;
        r_pos  <= n_pos;
        r_pair <= n_pair;
        if (w_accept) begin
            r_out_led    <= n_led;
            r_out_svalid <= n_out_svalid;
            r_out_sym    <= n_out_sym;
            r_out_locked <= n_rx_locked;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_locked, r_out_sym, r_out_led};
    assign o_m_axis_tuser  = r_out_svalid;

    a_svalid_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_svalid) |-> r_out_locked)
        else $error("decoded symbol reported without lock");

    a_edge_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= EDGE_LIMIT)
        else $error("edge count past limit");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < FRAME_TICKS)
        else $error("send phase out of frame");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_idx <= FILL_W'(PAYLOAD_BYTES))
        else $error("fill index past buffer");

    a_buf_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != 2'd3) && (r_next != 2'd3) && (r_sending == (r_active != BUF_NONE)))
        else $error("buffer selection inconsistent");

endmodule

// File: rtl/ppmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/tb_optical_ppm_transceiver.sv
// Testbench for optical_ppm_transceiver: directed and random tick, edge, payload and clear items,
// each result checked field by field against an in-bench model of the transceiver.
// Depends on ppmt_pkg and the transceiver RTL.
module tb_optical_ppm_transceiver;
    import ppmt_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        t_opcode           op;
        logic              level;
        logic [BYTE_W-1:0] data;
        logic              last;
    } ppm_item_t;

    typedef struct packed {
        logic             led;
        logic             sym_valid;
        logic [SYM_W-1:0] sym;
        logic             locked;
    } ppm_out_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_valid  = 1'b0;
    ppm_item_t            s_item   = '0;
    logic                 m_ready  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 s_ready;
    logic                 m_valid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    ppm_item_t ppm_in_q[$];
    ppm_out_t  ppm_exp_q[$];
    ppm_item_t drv_next;
    ppm_out_t  exp_out;
    logic      s_fire      = 1'b0;
    logic      steady      = 1'b0;
    int        fail_cnt    = 0;
    int        cycle_cnt   = 0;
    int        hold_asked  = 0;
    int        hold_served = 0;
    int        hold_left   = 0;

    // stimulus shaping
    int gen_now;
    int gen_len;
    int gen_timeout;

    // model state
    logic [CFG_W-1:0]    rise_after_cfg;
    logic [CFG_W-1:0]    timeout_cfg;
    logic [TIME_W-1:0]   tstamp;
    logic [PHASE_W-1:0]  tx_phase;
    logic                led;
    logic                rx_hunt;
    logic                rx_lock;
    logic [ECOUNT_W-1:0] edges_seen;
    logic [TIME_W-1:0]   edge_t [3];
    logic [BYTE_W-1:0]   store [STORE_DEPTH];
    logic [7:0]          buf_len [2];
    logic [7:0]          buf_byte [2];
    logic [PAIR_W-1:0]   buf_pair [2];
    logic [1:0]          tx_active;
    logic [1:0]          tx_next;
    logic                fill_sel;
    logic [7:0]          fill_cnt;
    logic                tx_busy;
    logic                pair_hi;
    logic                pair_lo;

    optical_ppm_transceiver u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({{(S_TDATA_W-BYTE_W-1){1'b0}}, s_item.data, s_item.level}),
        .i_s_axis_tuser  (s_item.op),
        .i_s_axis_tlast  (s_item.last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void rx_resync(input logic align_tx);
        tstamp     = 8'd1;
        edges_seen = '0;
        if (align_tx) tx_phase = PH_ALIGN;
        led = 1'b1;
    endfunction

    function automatic ppm_out_t ppm_predict(input ppm_item_t it);
        ppm_out_t          r;
        int                b;
        int                sh;
        int                half;
        int                quarter;
        int                d;
        int                late;
        logic [BYTE_W-1:0] v;
        logic [TIME_W-1:0] now;
        r = '0;
        case (it.op)
            OP_TICK: begin
                tstamp = tstamp + 1'b1;
                case (tx_phase)
                    PH_SYNC_RISE: led = 1'b1;
                    PH_HI0_OFF:   if (tx_busy && !pair_hi) led = 1'b0;
                    PH_HI0_ON:    if (tx_busy && !pair_hi) led = 1'b1;
                    PH_HI1_OFF:   if (tx_busy && pair_hi) led = 1'b0;
                    PH_HI1_ON:    if (tx_busy && pair_hi) led = 1'b1;
                    PH_SYNC_FALL: led = 1'b0;
                    PH_LO0_ON:    if (tx_busy && !pair_lo) led = 1'b1;
                    PH_LO0_OFF:   if (tx_busy && !pair_lo) led = 1'b0;
                    PH_LO1_ON:    if (tx_busy && pair_lo) led = 1'b1;
                    PH_LO1_OFF:   if (tx_busy && pair_lo) led = 1'b0;
                    default: ;
                endcase
                tx_phase = tx_phase + 1'b1;
                if (tx_phase >= FRAME_TICKS) tx_phase = '0;
                if (tx_phase == PH_LOAD) begin
                    if (tx_next != tx_active) begin
                        tx_active = tx_next;
                    end else if (tx_busy && tx_active != BUF_NONE) begin
                        b = (tx_active == BUF_SECOND) ? 1 : 0;
                        buf_pair[b] = buf_pair[b] + 1'b1;
                        if (buf_pair[b] == '0) begin
                            buf_byte[b] = buf_byte[b] + 1'b1;
                            if (buf_byte[b] >= buf_len[b]) buf_byte[b] = '0;
                        end
                    end
                    tx_busy = (tx_active != BUF_NONE);
                    if (tx_busy) begin
                        b  = (tx_active == BUF_SECOND) ? 1 : 0;
                        v  = (buf_byte[b] < PAYLOAD_BYTES) ?
                             store[b * PAYLOAD_BYTES + int'(buf_byte[b])] : '0;
                        sh = 2 * int'(buf_pair[b]);
                        pair_hi = v[7 - sh];
                        pair_lo = v[6 - sh];
                    end
                end
            end
            OP_EDGE: begin
                now = tstamp;
                if (rx_hunt || rx_lock) begin
                    if (edges_seen < EDGE_LIMIT) begin
                        if (edges_seen == 4'd0)      edge_t[0] = now;
                        else if (edges_seen == 4'd2) edge_t[1] = now;
                        else if (edges_seen == 4'd3) edge_t[2] = now;
                        edges_seen = edges_seen + 1'b1;
                    end
                    if (it.level && now > rise_after_cfg) begin
                        if (edges_seen == SYNC_EDGES) begin
                            rx_resync(1'b1);
                            rx_hunt = 1'b0;
                            rx_lock = 1'b1;
                        end else if (edges_seen > MIN_DATA_EDGES) begin
                            if (edges_seen == DECODE_EDGES) begin
                                half    = int'(edge_t[1]);
                                quarter = half / 2;
                                d       = int'(now) - half;
                                late    = (d / 2 + half) & 255;
                                r.sym[1] = (int'(edge_t[0]) >= quarter);
                                r.sym[0] = (int'(edge_t[2]) >= late);
                                r.sym_valid = 1'b1;
                                rx_resync(1'b1);
                                rx_hunt = 1'b0;
                                rx_lock = 1'b1;
                            end else begin
                                rx_lock = 1'b0;
                                rx_resync(1'b0);
                            end
                        end
                    end else if (now > timeout_cfg) begin
                        rx_lock = 1'b0;
                        if (it.level) begin
                            rx_resync(1'b0);
                            rx_hunt = 1'b1;
                        end else begin
                            rx_hunt = 1'b0;
                        end
                    end
                end else if (it.level) begin
                    rx_resync(1'b0);
                    rx_hunt = 1'b1;
                end
            end
            OP_BYTE: begin
                if (fill_cnt == '0) fill_sel = (tx_next == BUF_FIRST);
                if (fill_cnt < PAYLOAD_BYTES) begin
                    store[int'(fill_sel) * PAYLOAD_BYTES + int'(fill_cnt)] = it.data;
                    fill_cnt = fill_cnt + 1'b1;
                end
                if (it.last) begin
                    buf_len[fill_sel]  = fill_cnt;
                    buf_byte[fill_sel] = '0;
                    buf_pair[fill_sel] = '0;
                    tx_next  = fill_sel ? BUF_SECOND : BUF_FIRST;
                    fill_cnt = '0;
                end
            end
            default: tx_next = BUF_NONE;
        endcase
        r.led    = led;
        r.locked = rx_lock;
        return r;
    endfunction

    // accept items, predict, and check results
    always @(posedge clk) begin
        s_fire = 1'b0;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (ppm_exp_q.size() == 0) begin
                    $error("result item with no expected result: tdata %h", m_tdata);
                    fail_cnt++;
                end else begin
                    exp_out = ppm_exp_q.pop_front();
                    if (m_tdata[0] !== exp_out.led) begin
                        $error("led_on: expected %0d, got %0d", exp_out.led, m_tdata[0]);
                        fail_cnt++;
                    end
                    if (m_tuser !== exp_out.sym_valid) begin
                        $error("symbol_valid: expected %0d, got %0d", exp_out.sym_valid, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[2:1] !== exp_out.sym) begin
                        $error("symbol: expected %0d, got %0d", exp_out.sym, m_tdata[2:1]);
                        fail_cnt++;
                    end
                    if (m_tdata[3] !== exp_out.locked) begin
                        $error("locked: expected %0d, got %0d", exp_out.locked, m_tdata[3]);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                s_fire = 1'b1;
                ppm_exp_q.push_back(ppm_predict(s_item));
            end
        end
    end

    // driver: present the next pending item, idling at random
    always @(negedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (ppm_in_q.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
                drv_next = ppm_in_q.pop_front();
                s_valid <= 1'b1;
                s_item  <= drv_next;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls plus requested long holds
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_item(input t_opcode op, input logic lvl, input logic [BYTE_W-1:0] d,
                             input logic lst);
        ppm_item_t it;
        it.op    = op;
        it.level = lvl;
        it.data  = d;
        it.last  = lst;
        ppm_in_q.push_back(it);
    endtask

    task automatic gen_noise(input int n);
        repeat (n)
            push_item(t_opcode'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // one tick, with payload traffic mixed in
    task automatic gen_tick();
        int roll;
        roll = $urandom_range(0, 99);
        push_item(OP_TICK, 1'($urandom), 8'($urandom), 1'($urandom));
        gen_now++;
        if (roll < 10)
            push_item(OP_BYTE, 1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
        else if (roll == 99)
            push_item(OP_CLEAR, 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic gen_edge_at(input int t, input logic lvl);
        while (gen_now < t) gen_tick();
        push_item(OP_EDGE, lvl, 8'($urandom), 1'($urandom));
    endtask

    task automatic gen_preamble();
        push_item(OP_EDGE, 1'b1, 8'($urandom), 1'($urandom));
        gen_now = 1;
        gen_edge_at(12, 1'b0);
        gen_edge_at(gen_len + $urandom_range(0, 1), 1'b1);
        gen_now = 1;
    endtask

    // mostly clean frames with every data edge; some drop an edge, add pulses or run into the timeout
    task automatic gen_frame();
        int mode;
        int a;
        int b;
        int skip;
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            gen_edge_at(gen_now + gen_timeout + 2, 1'b0);
            gen_preamble();
        end else begin
            a    = ($urandom_range(0, 1) ? 7 : 3) + $urandom_range(0, 1);
            b    = ($urandom_range(0, 1) ? 19 : 15) + $urandom_range(0, 1);
            skip = (mode == 7) ? $urandom_range(0, 4) : -1;
            if (skip != 0) gen_edge_at(a, 1'b0);
            if (skip != 1) gen_edge_at(a + 2, 1'b1);
            if (skip != 2) gen_edge_at(12, 1'b0);
            if (mode == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    gen_edge_at(gen_now, 1'b1);
                    gen_edge_at(gen_now, 1'b0);
                end
            end
            if (skip != 3) gen_edge_at(b, 1'b1);
            if (skip != 4) gen_edge_at(b + 2, 1'b0);
            gen_edge_at(gen_len + $urandom_range(0, 1), 1'b1);
            gen_now = 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC_RISE) rise_after_cfg = val;
        else timeout_cfg = val;
    endtask

    task automatic drain();
        while (ppm_in_q.size() != 0 || s_valid || ppm_exp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int rise;
        rise_after_cfg = SYNC_RISE_RESET;
        timeout_cfg    = LOCK_TIMEOUT_RESET;
        tstamp     = '0;
        tx_phase   = '0;
        led        = 1'b0;
        rx_hunt    = 1'b0;
        rx_lock    = 1'b0;
        edges_seen = '0;
        foreach (edge_t[k]) edge_t[k] = '0;
        foreach (store[k]) store[k] = '0;
        foreach (buf_len[k]) begin
            buf_len[k]  = '0;
            buf_byte[k] = '0;
            buf_pair[k] = '0;
        end
        tx_active = BUF_NONE;
        tx_next   = BUF_NONE;
        fill_sel  = 1'b0;
        fill_cnt  = '0;
        tx_busy   = 1'b0;
        pair_hi   = 1'b0;
        pair_lo   = 1'b0;
        gen_now   = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_SYNC_RISE, 8'd22);
        write_reg(CFG_LOCK_TIMEOUT, 8'd25);
        gen_len     = 24;
        gen_timeout = 25;

        push_item(OP_EDGE, 1'b0, 8'hFF, 1'b1);
        push_item(OP_TICK, 1'b1, 8'hFF, 1'b1);
        push_item(OP_BYTE, 1'b1, 8'h00, 1'b0);
        push_item(OP_BYTE, 1'b0, 8'hFF, 1'b1);
        push_item(OP_BYTE, 1'b0, 8'hA5, 1'b1);
        push_item(OP_CLEAR, 1'b1, 8'hFF, 1'b1);
        push_item(OP_BYTE, 1'b1, 8'h3C, 1'b1);
        repeat (4) push_item(OP_TICK, 1'b0, 8'h00, 1'b0);
        // burst of edges past the per-frame edge limit
        for (int k = 0; k < 12; k++) push_item(OP_EDGE, k % 2 == 0, 8'h00, 1'b0);
        push_item(OP_CLEAR, 1'b0, 8'h00, 1'b0);

        gen_preamble();
        repeat (2) gen_frame();
        // oversized payload: bytes past the buffer size are dropped
        for (int k = 0; k < 70; k++) push_item(OP_BYTE, 1'($urandom), 8'($urandom), k == 69);
        hold_asked++;
        drain();

        write_reg(CFG_SYNC_RISE, 8'd0);
        write_reg(CFG_LOCK_TIMEOUT, 8'd0);
        gen_timeout = 0;
        gen_noise(15);
        gen_preamble();
        gen_frame();
        drain();

        write_reg(CFG_SYNC_RISE, 8'd255);
        write_reg(CFG_LOCK_TIMEOUT, 8'd255);
        gen_noise(15);
        gen_preamble();
        drain();

        steady = 1'b1;
        rise = $urandom_range(14, 40);
        write_reg(CFG_SYNC_RISE, 8'(rise));
        gen_timeout = rise + $urandom_range(2, 20);
        write_reg(CFG_LOCK_TIMEOUT, 8'(gen_timeout));
        gen_len = (rise + 1 > 24) ? rise + 1 : 24;
        gen_preamble();
        gen_frame();
        hold_asked++;
        drain();
        steady = 1'b0;

        write_reg(CFG_SYNC_RISE, 8'd22);
        write_reg(CFG_LOCK_TIMEOUT, 8'd25);
        gen_len     = 24;
        gen_timeout = 25;
        gen_preamble();
        gen_noise(10);
        drain();

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/ppmt_pkg.sv
rtl/ppmt_ram.sv
rtl/optical_ppm_transceiver.sv
test/tb_optical_ppm_transceiver.sv
